// ===== src/assert_macros.svh =====
// shared assertion macros for the request table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds on every clock edge outside reset
`define PRT_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define PRT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PRT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define PRT_ASSERT(label, clk, rst, expr)
`define PRT_IMPLY(label, clk, rst, ante, cons)
`define PRT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/prt_pkg.sv =====
package prt_pkg;

   localparam int MODES    = 8;
   localparam int MODE_W   = 3;
   localparam int PRIO_W   = 8;
   localparam int SERIAL_W = 64;
   localparam int SOURCE_W = 8;
   localparam int HANDLE_W = 4;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 3;
   localparam int OP_W     = 3;

   localparam int DEFAULT_SLOTS       = 16;
   localparam int DEFAULT_SOURCE_BITS = 8;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_ENABLED    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MODE_MASK  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_PRIORITIES = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_FALLBACK   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_MODE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE     = 3'd0,
      OP_RELEASE     = 3'd1,
      OP_RELEASE_SRC = 3'd2,
      OP_QUERY       = 3'd3,
      OP_COUNT       = 3'd4,
      OP_IS_ACTIVE   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_RUN,
      CTRL_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic [OP_W-1:0]     req_type;
      logic [MODE_W-1:0]   mode;
      logic [SOURCE_W-1:0] source_id;
      logic [HANDLE_W-1:0] handle_slot;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [MODE_W-1:0]   active_mode;
      logic [COUNT_W-1:0]  count;
      logic                is_winner;
   } rsp_item_type;

   typedef struct packed {
      logic                       enabled;
      logic [MODES-1:0]           present_mask;
      logic [MODES*PRIO_W-1:0]    priorities;
      logic [MODE_W-1:0]          fallback_mode;
   } cfg_type;

   // request fields broadcast to every cell while a pass runs
   typedef struct packed {
      op_type              op;
      logic [MODE_W-1:0]   mode;
      logic [SOURCE_W-1:0] source_id;
      logic [HANDLE_W-1:0] handle_slot;
      logic [SERIAL_W-1:0] serial;
      logic                claim_en;
   } cmd_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic                claimed;
      logic [SLOT_W-1:0]   claim_slot;
      logic                released;
      logic                hs_used;
      logic                hs_mode_ok;
      logic [COUNT_W-1:0]  count;
      logic                best_valid;
      logic [PRIO_W-1:0]   best_prio;
      logic [SERIAL_W-1:0] best_serial;
      logic [SLOT_W-1:0]   best_slot;
      logic [MODE_W-1:0]   best_mode;
      logic                best_is_hs;
   } pass_type;

endpackage

// ===== src/priority_request_table.sv =====
// Table of mode requests with a priority arbiter. Every slot is one cell of a chain; a request
// is carried as a token that walks the chain one cell per clock, and each cell acquires,
// releases, counts or compares its own entry as the token passes. One request is in flight at
// a time: the token is launched from a register, passes every cell and lands in the result
// register, and the next request is taken only once that result has moved on to the output
// register. The output register keeps a finished result while the consumer stalls.
// Configuration registers sit at byte addresses 0, 8, 16 and 24 (enabled, mode present mask,
// packed mode priorities, fallback mode) and must only be written while no request is
// outstanding.
`include "assert_macros.svh"

module priority_request_table #(
   parameter int SLOTS       = prt_pkg::DEFAULT_SLOTS,
   parameter int SOURCE_BITS = prt_pkg::DEFAULT_SOURCE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  prt_pkg::req_item_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output prt_pkg::rsp_item_type              rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [prt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [prt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [prt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int SRC_W = (SOURCE_BITS < prt_pkg::SOURCE_W) ? SOURCE_BITS : prt_pkg::SOURCE_W;

   prt_pkg::cfg_type                   cfg;
   logic [prt_pkg::MODES-1:0]          present;
   prt_pkg::ctrl_state_type            state_ff, state_in;
   prt_pkg::cmd_type                   cmd_ff, cmd_in;
   logic [prt_pkg::STATUS_W-1:0]       pre_status_ff, pre_status_in;
   logic [prt_pkg::SERIAL_W-1:0]       last_serial_ff, last_serial_in;
   logic                               launch_ff;
   prt_pkg::rsp_item_type              res_ff, res_in;
   prt_pkg::rsp_item_type              rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [SLOTS:0]                     tok_valid;
   prt_pkg::pass_type                  tok [SLOTS+1];
   prt_pkg::pass_type                  tok_end;
   logic                               chain_done;
   logic                               grant_done;
   logic                               start;
   logic                               rsp_load;
   logic                               rsp_free;
   logic                               mode_ok;
   prt_pkg::op_type                    req_op;

   prt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // a mode counts only if it is below MODES and its mask bit is set
   always_comb begin
      for (int m = 0; m < prt_pkg::MODES; m++) begin
         present[m] = cfg.present_mask[m] && (m < prt_pkg::MODES);
      end
   end

   assign tok_valid[0] = launch_ff;
   assign tok[0]       = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      prt_cell #(
         .INDEX (i),
         .SRC_W (SRC_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .present       (present),
         .priorities    (cfg.priorities),
         .cmd           (cmd_ff),
         .tok_valid_in  (tok_valid[i]),
         .tok_in        (tok[i]),
         .tok_valid_out (tok_valid[i+1]),
         .tok_out       (tok[i+1])
      );
   end

   assign tok_end    = tok[SLOTS];
   assign chain_done = tok_valid[SLOTS];
   assign grant_done = chain_done && tok_end.claimed && (cmd_ff.op == prt_pkg::OP_ACQUIRE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prt_pkg::CTRL_IDLE:   if (req_valid)  state_in = prt_pkg::CTRL_RUN;
         prt_pkg::CTRL_RUN:    if (chain_done) state_in = prt_pkg::CTRL_FINISH;
         prt_pkg::CTRL_FINISH: if (rsp_free)   state_in = prt_pkg::CTRL_IDLE;
         default:              state_in = prt_pkg::CTRL_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall = 1'b1;
      start     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         prt_pkg::CTRL_IDLE: begin
            req_stall = 1'b0;
            start     = req_valid;
         end
         prt_pkg::CTRL_RUN: ;
         prt_pkg::CTRL_FINISH: rsp_load = rsp_free;
         default: ;
      endcase
   end

   // request decode and acquire checks at accept
   assign req_op  = prt_pkg::op_type'(req_data.req_type);
   assign mode_ok = (req_data.mode != cfg.fallback_mode) && present[req_data.mode];

   always_comb begin
      cmd_in             = cmd_ff;
      pre_status_in      = pre_status_ff;
      if (start) begin
         cmd_in.op          = req_op;
         cmd_in.mode        = req_data.mode;
         cmd_in.source_id   = req_data.source_id;
         cmd_in.handle_slot = req_data.handle_slot;
         cmd_in.serial      = last_serial_ff + prt_pkg::SERIAL_W'(1);
         if (!cfg.enabled) begin
            pre_status_in = prt_pkg::ST_DISABLED;
         end else if (!mode_ok) begin
            pre_status_in = prt_pkg::ST_BAD_MODE;
         end else if (&last_serial_ff) begin
            pre_status_in = prt_pkg::ST_EXHAUSTED;
         end else begin
            pre_status_in = prt_pkg::ST_OK;
         end
         cmd_in.claim_en = (req_op == prt_pkg::OP_ACQUIRE) && cfg.enabled && mode_ok &&
                           !(&last_serial_ff);
      end
   end

   // result from the token leaving the last cell
   always_comb begin
      res_in         = res_ff;
      last_serial_in = last_serial_ff;
      if (chain_done) begin
         res_in = '0;
         unique case (cmd_ff.op) inside
            prt_pkg::OP_ACQUIRE: begin
               if (pre_status_ff != prt_pkg::ST_OK) begin
                  res_in.status = pre_status_ff;
               end else if (tok_end.claimed) begin
                  res_in.status  = prt_pkg::ST_OK;
                  res_in.slot    = tok_end.claim_slot;
                  last_serial_in = cmd_ff.serial;
               end else begin
                  res_in.status = prt_pkg::ST_FULL;
               end
            end
            prt_pkg::OP_RELEASE: begin
               if (tok_end.released) begin
                  res_in.status = prt_pkg::ST_OK;
                  res_in.slot   = cmd_ff.handle_slot;
                  res_in.count  = prt_pkg::COUNT_W'(1);
               end else begin
                  res_in.status = prt_pkg::ST_NOT_FOUND;
               end
            end
            prt_pkg::OP_RELEASE_SRC, prt_pkg::OP_COUNT: begin
               res_in.status = prt_pkg::ST_OK;
               res_in.count  = tok_end.count;
            end
            prt_pkg::OP_QUERY: begin
               if (!cfg.enabled) begin
                  res_in.status = prt_pkg::ST_DISABLED;
               end else if (tok_end.best_valid) begin
                  res_in.status      = prt_pkg::ST_OK;
                  res_in.slot        = tok_end.best_slot;
                  res_in.active_mode = tok_end.best_mode;
               end else begin
                  res_in.status      = prt_pkg::ST_NOT_FOUND;
                  res_in.active_mode = cfg.fallback_mode;
               end
            end
            prt_pkg::OP_IS_ACTIVE: begin
               if (!cfg.enabled) begin
                  res_in.status = prt_pkg::ST_DISABLED;
               end else if (!tok_end.hs_used) begin
                  res_in.status = prt_pkg::ST_NOT_FOUND;
               end else begin
                  res_in.status    = prt_pkg::ST_OK;
                  res_in.is_winner = tok_end.best_valid && tok_end.best_is_hs &&
                                     tok_end.hs_mode_ok;
               end
            end
            default: res_in.status = prt_pkg::ST_BAD_MODE;
         endcase
      end
   end

   assign rsp_in       = rsp_load ? res_ff : rsp_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= prt_pkg::CTRL_IDLE;
         launch_ff      <= 1'b0;
         last_serial_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         launch_ff      <= start;
         last_serial_ff <= last_serial_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pre_status_ff <= pre_status_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PRT_ASSERT(a_single_token, clock, reset, $onehot0(tok_valid))
   `PRT_IMPLY(a_token_only_in_run, clock, reset, (|tok_valid), state_ff == prt_pkg::CTRL_RUN)
   `PRT_NEXT(a_serial_only_on_grant, clock, reset, !grant_done, $stable(last_serial_ff))

endmodule

// ===== src/prt_csr.sv =====
module prt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [prt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [prt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [prt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output prt_pkg::cfg_type                   cfg
);

   logic                                           enabled_ff, enabled_in;
   logic [prt_pkg::MODES-1:0]                      mask_ff, mask_in;
   logic [prt_pkg::MODES*prt_pkg::PRIO_W-1:0]      prio_ff, prio_in;
   logic [prt_pkg::MODE_W-1:0]                     fallback_ff, fallback_in;
   logic                                           wr_en;
   logic [prt_pkg::REG_IDX_W-1:0]                  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[prt_pkg::CSR_ADDR_W-1:3];

   always_comb begin
      enabled_in  = enabled_ff;
      mask_in     = mask_ff;
      prio_in     = prio_ff;
      fallback_in = fallback_ff;
      if (wr_en) begin
         unique case (reg_idx)
            prt_pkg::REG_ENABLED:    enabled_in  = csr_pwdata[0];
            prt_pkg::REG_MODE_MASK:  mask_in     = csr_pwdata[prt_pkg::MODES-1:0];
            prt_pkg::REG_PRIORITIES: prio_in     =
               csr_pwdata[prt_pkg::MODES*prt_pkg::PRIO_W-1:0];
            prt_pkg::REG_FALLBACK:   fallback_in = csr_pwdata[prt_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         prt_pkg::REG_ENABLED:    csr_prdata[0] = enabled_ff;
         prt_pkg::REG_MODE_MASK:  csr_prdata[prt_pkg::MODES-1:0] = mask_ff;
         prt_pkg::REG_PRIORITIES: csr_prdata[prt_pkg::MODES*prt_pkg::PRIO_W-1:0] = prio_ff;
         prt_pkg::REG_FALLBACK:   csr_prdata[prt_pkg::MODE_W-1:0] = fallback_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         mask_ff     <= '0;
         prio_ff     <= '0;
         fallback_ff <= '0;
      end else begin
         enabled_ff  <= enabled_in;
         mask_ff     <= mask_in;
         prio_ff     <= prio_in;
         fallback_ff <= fallback_in;
      end
   end

   assign cfg.enabled       = enabled_ff;
   assign cfg.present_mask  = mask_ff;
   assign cfg.priorities    = prio_ff;
   assign cfg.fallback_mode = fallback_ff;

endmodule

// ===== src/prt_cell.sv =====
module prt_cell #(
   parameter int INDEX = 0,
   parameter int SRC_W = prt_pkg::DEFAULT_SOURCE_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [prt_pkg::MODES-1:0]                   present,
   input  logic [prt_pkg::MODES*prt_pkg::PRIO_W-1:0]   priorities,
   input  prt_pkg::cmd_type                            cmd,
   input  logic                                        tok_valid_in,
   input  prt_pkg::pass_type                           tok_in,
   output logic                                        tok_valid_out,
   output prt_pkg::pass_type                           tok_out
);

   localparam logic HS_REACH = (INDEX < (1 << prt_pkg::HANDLE_W));
   localparam logic [prt_pkg::SLOT_W-1:0]   MY_SLOT   = prt_pkg::SLOT_W'(INDEX);
   localparam logic [prt_pkg::HANDLE_W-1:0] MY_HANDLE = prt_pkg::HANDLE_W'(INDEX);

   logic                            used_ff, used_in;
   logic [prt_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [SRC_W-1:0]                source_ff, source_in;
   logic [prt_pkg::SERIAL_W-1:0]    serial_ff, serial_in;
   logic                            tok_valid_ff;
   prt_pkg::pass_type               tok_ff, tok_next;
   logic                            hs_hit;
   logic                            src_hit;
   logic                            eligible;
   logic                            better;
   logic [prt_pkg::PRIO_W-1:0]      prio;

   assign hs_hit   = HS_REACH && (cmd.handle_slot == MY_HANDLE);
   assign src_hit  = used_ff && (source_ff == cmd.source_id[SRC_W-1:0]);
   assign eligible = used_ff && present[mode_ff];
   assign prio     = priorities[{mode_ff, 3'b000} +: prt_pkg::PRIO_W];
   // equal priority goes to the newer serial
   assign better   = !tok_in.best_valid || (prio > tok_in.best_prio) ||
                     ((prio == tok_in.best_prio) && (serial_ff > tok_in.best_serial));

   always_comb begin
      used_in   = used_ff;
      mode_in   = mode_ff;
      source_in = source_ff;
      serial_in = serial_ff;
      tok_next  = tok_in;
      if (tok_valid_in) begin
         unique case (cmd.op) inside
            prt_pkg::OP_ACQUIRE: begin
               if (cmd.claim_en && !tok_in.claimed && !used_ff) begin
                  used_in             = 1'b1;
                  mode_in             = cmd.mode;
                  source_in           = cmd.source_id[SRC_W-1:0];
                  serial_in           = cmd.serial;
                  tok_next.claimed    = 1'b1;
                  tok_next.claim_slot = MY_SLOT;
               end
            end
            prt_pkg::OP_RELEASE: begin
               if (hs_hit && used_ff && (mode_ff == cmd.mode)) begin
                  used_in           = 1'b0;
                  tok_next.released = 1'b1;
               end
            end
            prt_pkg::OP_RELEASE_SRC, prt_pkg::OP_COUNT: begin
               if (src_hit) begin
                  if (tok_in.count != prt_pkg::COUNT_MAX) begin
                     tok_next.count = tok_in.count + prt_pkg::COUNT_W'(1);
                  end
                  if (cmd.op == prt_pkg::OP_RELEASE_SRC) begin
                     used_in = 1'b0;
                  end
               end
            end
            prt_pkg::OP_QUERY, prt_pkg::OP_IS_ACTIVE: begin
               if (hs_hit) begin
                  tok_next.hs_used    = used_ff;
                  tok_next.hs_mode_ok = (mode_ff == cmd.mode);
               end
               if (eligible && better) begin
                  tok_next.best_valid  = 1'b1;
                  tok_next.best_prio   = prio;
                  tok_next.best_serial = serial_ff;
                  tok_next.best_slot   = MY_SLOT;
                  tok_next.best_mode   = mode_ff;
                  tok_next.best_is_hs  = hs_hit;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      source_ff <= source_in;
      serial_ff <= serial_in;
      tok_ff    <= tok_next;
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_out       = tok_ff;

endmodule
